>>> rtl/json_string_unescape_utf8_defines.svh
// Assertion macros shared by the JSON string unescape RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define JSU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define JSU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu assertion failed");
`else
`define JSU_ASSERT_IMP(label, clk, rst, ante, cons)
`define JSU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/jsu_pkg.sv
// Types, constants and helper functions of the JSON string unescape block.
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] status;
    logic       last;
  } out_t;

  // Most beats one input item can cause.
  localparam int BurstMax = 6;

  typedef struct packed {
    out_t [3:0] rec;
    logic [2:0] len;
  } seg_t;

  typedef struct packed {
    out_t [BurstMax-1:0] rec;
    logic [2:0]          count;
  } burst_t;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_BAD_ESCAPE  = 3'd1;
  localparam logic [2:0] STATUS_BAD_HEX     = 3'd2;
  localparam logic [2:0] STATUS_SHORT_HEX   = 3'd3;
  localparam logic [2:0] STATUS_NO_QUOTE    = 3'd4;
  localparam logic [2:0] STATUS_OPEN_ESCAPE = 3'd5;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] LIMIT_1BYTE   = 21'h80;
  localparam logic [20:0] LIMIT_2BYTE   = 21'h800;
  localparam logic [7:0]  UTF8_CONT     = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4    = 8'hF0;

  function automatic out_t mk_byte(logic [7:0] b);
    out_t r;
    r            = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic seg_t seg_one(out_t r);
    seg_t s;
    s        = '0;
    s.rec[0] = r;
    s.len    = 3'd1;
    return s;
  endfunction

  function automatic seg_t seg_utf8(logic [20:0] c);
    seg_t s;
    s = '0;
    if (c < LIMIT_1BYTE) begin
      s.rec[0] = mk_byte(c[7:0]);
      s.len    = 3'd1;
    end else if (c < LIMIT_2BYTE) begin
      s.rec[0] = mk_byte(UTF8_LEAD2 | {3'b000, c[10:6]});
      s.rec[1] = mk_byte(UTF8_CONT | {2'b00, c[5:0]});
      s.len    = 3'd2;
    end else if (c < SUPP_BASE) begin
      s.rec[0] = mk_byte(UTF8_LEAD3 | {4'b0000, c[15:12]});
      s.rec[1] = mk_byte(UTF8_CONT | {2'b00, c[11:6]});
      s.rec[2] = mk_byte(UTF8_CONT | {2'b00, c[5:0]});
      s.len    = 3'd3;
    end else begin
      s.rec[0] = mk_byte(UTF8_LEAD4 | {5'b00000, c[20:18]});
      s.rec[1] = mk_byte(UTF8_CONT | {2'b00, c[17:12]});
      s.rec[2] = mk_byte(UTF8_CONT | {2'b00, c[11:6]});
      s.rec[3] = mk_byte(UTF8_CONT | {2'b00, c[5:0]});
      s.len    = 3'd4;
    end
    return s;
  endfunction

endpackage

>>> rtl/jsu_decode.sv
// Escape decoder: scan state registers and the per-byte result builder.
module jsu_decode
  import jsu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  in_t    in_data,
  input  logic   take,
  output burst_t burst
);

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX   = 3'd2,
    MODE_HWAIT = 3'd3,
    MODE_HESC  = 3'd4
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] pending_high, pending_high_next;
  logic        pending_valid, pending_valid_next;

  logic        go_plain, fail_now, clear_now;
  logic [2:0]  fail_code;
  logic        digit_ok, simple_ok;
  logic [3:0]  digit;
  logic [7:0]  simple_byte;
  logic [15:0] code;
  seg_t        seg_a, seg_b;
  logic [3:0]  total, pos, off;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (in_data.in_byte inside {[8'h30:8'h39]}) begin
      digit = 4'(in_data.in_byte - 8'h30);
    end else if (in_data.in_byte inside {[8'h61:8'h66]}) begin
      digit = 4'(in_data.in_byte - 8'h57);
    end else if (in_data.in_byte inside {[8'h41:8'h46]}) begin
      digit = 4'(in_data.in_byte - 8'h37);
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    simple_ok   = 1'b1;
    simple_byte = 8'h00;
    case (in_data.in_byte)
      CH_QUOTE:     simple_byte = CH_QUOTE;
      CH_BACKSLASH: simple_byte = CH_BACKSLASH;
      CH_SLASH:     simple_byte = CH_SLASH;
      8'h62:        simple_byte = 8'h08;
      8'h66:        simple_byte = 8'h0C;
      8'h6E:        simple_byte = 8'h0A;
      8'h72:        simple_byte = 8'h0D;
      8'h74:        simple_byte = 8'h09;
      default:      simple_ok   = 1'b0;
    endcase
  end

  always_comb begin
    mode_next          = mode;
    hex_accum_next     = hex_accum;
    hex_count_next     = hex_count;
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    seg_a              = '0;
    seg_b              = '0;
    go_plain           = 1'b0;
    fail_now           = 1'b0;
    clear_now          = 1'b0;
    fail_code          = STATUS_OK;
    code               = {hex_accum[11:0], digit};

    case (mode)
      MODE_HWAIT: begin
        if (in_data.text_end) begin
          fail_now  = 1'b1;
          fail_code = STATUS_NO_QUOTE;
        end else if (in_data.in_byte == CH_BACKSLASH) begin
          mode_next = MODE_HESC;
        end else begin
          // The held high surrogate was not followed by an escape: flush it.
          seg_a              = seg_utf8({5'b00000, pending_high});
          pending_high_next  = '0;
          pending_valid_next = 1'b0;
          mode_next          = MODE_PLAIN;
          go_plain           = 1'b1;
        end
      end
      MODE_ESC, MODE_HESC: begin
        if (in_data.text_end) begin
          fail_now  = 1'b1;
          fail_code = STATUS_OPEN_ESCAPE;
        end else if (in_data.in_byte == CH_U) begin
          mode_next      = MODE_HEX;
          hex_accum_next = '0;
          hex_count_next = '0;
        end else if (!simple_ok) begin
          fail_now  = 1'b1;
          fail_code = STATUS_BAD_ESCAPE;
        end else begin
          if (mode == MODE_HESC) begin
            seg_a = seg_utf8({5'b00000, pending_high});
          end
          pending_high_next  = '0;
          pending_valid_next = 1'b0;
          seg_b              = seg_one(mk_byte(simple_byte));
          mode_next          = MODE_PLAIN;
        end
      end
      MODE_HEX: begin
        if (in_data.text_end) begin
          fail_now  = 1'b1;
          fail_code = STATUS_SHORT_HEX;
        end else if (!digit_ok) begin
          fail_now  = 1'b1;
          fail_code = STATUS_BAD_HEX;
        end else if (hex_count != 2'd3) begin
          hex_accum_next = code;
          hex_count_next = hex_count + 2'd1;
        end else begin
          hex_accum_next     = '0;
          hex_count_next     = '0;
          mode_next          = MODE_PLAIN;
          pending_high_next  = '0;
          pending_valid_next = 1'b0;
          if (pending_valid && code >= LOW_SURR_MIN && code <= LOW_SURR_MAX) begin
            // High and low surrogate pair into one supplementary code point.
            seg_b = seg_utf8(SUPP_BASE + 21'({pending_high[9:0], code[9:0]}));
          end else begin
            if (pending_valid) begin
              seg_a = seg_utf8({5'b00000, pending_high});
            end
            if (code >= HIGH_SURR_MIN && code <= HIGH_SURR_MAX) begin
              pending_high_next  = code;
              pending_valid_next = 1'b1;
              mode_next          = MODE_HWAIT;
            end else begin
              seg_b = seg_utf8({5'b00000, code});
            end
          end
        end
      end
      default: go_plain = 1'b1;
    endcase

    if (go_plain) begin
      if (in_data.text_end) begin
        fail_now  = 1'b1;
        fail_code = STATUS_NO_QUOTE;
      end else if (in_data.in_byte == CH_QUOTE) begin
        clear_now             = 1'b1;
        seg_b                 = '0;
        seg_b.rec[0].string_done = 1'b1;
        seg_b.len             = 3'd1;
      end else if (in_data.in_byte == CH_BACKSLASH) begin
        mode_next = MODE_ESC;
      end else begin
        mode_next = MODE_PLAIN;
        seg_b     = seg_one(mk_byte(in_data.in_byte));
      end
    end

    if (fail_now) begin
      // Errors drop any held surrogate and report a single status beat.
      clear_now           = 1'b1;
      seg_a               = '0;
      seg_b               = '0;
      seg_b.rec[0].status = fail_code;
      seg_b.len           = 3'd1;
    end

    if (clear_now) begin
      mode_next          = MODE_PLAIN;
      hex_accum_next     = '0;
      hex_count_next     = '0;
      pending_high_next  = '0;
      pending_valid_next = 1'b0;
    end
  end

  // Splice the two segments into one burst and flag its final beat.
  always_comb begin
    burst       = '0;
    total       = {1'b0, seg_a.len} + {1'b0, seg_b.len};
    burst.count = total[2:0];
    pos         = '0;
    off         = '0;
    for (int i = 0; i < BurstMax; i++) begin
      pos = 4'(i);
      off = pos - {1'b0, seg_a.len};
      if (pos < {1'b0, seg_a.len}) begin
        burst.rec[i] = seg_a.rec[pos[1:0]];
      end else if (off < {1'b0, seg_b.len}) begin
        burst.rec[i] = seg_b.rec[off[1:0]];
      end
      if (pos == total - 4'd1) begin
        burst.rec[i].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PLAIN;
      hex_accum     <= '0;
      hex_count     <= '0;
      pending_high  <= '0;
      pending_valid <= 1'b0;
    end else if (take) begin
      mode          <= mode_next;
      hex_accum     <= hex_accum_next;
      hex_count     <= hex_count_next;
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
    end
  end

endmodule

>>> rtl/jsu_burst_queue.sv
// Two-slot result queue that streams each registered burst out one beat at a time.
`include "json_string_unescape_utf8_defines.svh"

module jsu_burst_queue
  import jsu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  burst_t burst,
  input  logic   push_req,
  output logic   can_push,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  burst_t     slot_burst [2];
  logic [1:0] slot_full, slot_full_next;
  logic       wr_ptr, rd_ptr;
  logic [2:0] idx;
  logic       push, pop, pop_final, final_beat;

  assign can_push   = !slot_full[wr_ptr];
  assign push       = push_req && can_push && (burst.count != 3'd0);
  assign out_valid  = slot_full[rd_ptr];
  assign out_data   = slot_burst[rd_ptr].rec[idx];
  assign pop        = out_valid && out_ready;
  assign final_beat = (idx == slot_burst[rd_ptr].count - 3'd1);
  assign pop_final  = pop && final_beat;

  // A push and a final pop never touch the same slot in one cycle.
  always_comb begin
    slot_full_next = slot_full;
    if (push) begin
      slot_full_next[wr_ptr] = 1'b1;
    end
    if (pop_final) begin
      slot_full_next[rd_ptr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_burst[wr_ptr] <= burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= '0;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      idx       <= '0;
    end else begin
      slot_full <= slot_full_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_final) begin
        rd_ptr <= !rd_ptr;
        idx    <= '0;
      end else if (pop) begin
        idx <= idx + 3'd1;
      end
    end
  end

  `JSU_ASSERT_IMP(a_slot_not_empty, clk, rst, out_valid, slot_burst[rd_ptr].count != 3'd0)
  `JSU_ASSERT_IMP(a_idx_in_burst, clk, rst, out_valid, idx < slot_burst[rd_ptr].count)
  `JSU_ASSERT_IMP(a_last_on_final, clk, rst, out_valid, out_data.last == final_beat)
  `JSU_ASSERT_NXT(a_final_frees_slot, clk, rst, pop_final, rd_ptr != $past(rd_ptr) && idx == 3'd0)

endmodule

>>> rtl/json_string_unescape_utf8.sv
// A result burst is registered into a free queue slot as its input beat is accepted.
// Throughput: one input beat per cycle while each item yields at most one beat and
// the receiver takes every beat; an item that yields N beats (up to six for a
// flushed surrogate plus a code point) holds the output until all N are taken; the
// second slot takes one more item meanwhile; then input waits until a slot is freed.
// Reset: synchronous, active high; returns to plain body mode with empty result slots.
// Top level of the JSON string body unescaper with UTF-8 output.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // The decoder works combinationally from the scan state and the incoming
  // beat; its burst of results is captured in a free queue slot on the same
  // edge that accepts the beat and advances the scan state. Input readiness
  // therefore depends only on whether the slot about to be written is free,
  // never on out_ready, so the two sides are decoupled by registers.
  logic   take;
  burst_t burst;

  assign take = in_valid && in_ready;

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .take    (take),
    .burst   (burst)
  );

  // The queue replays each burst beat by beat; the last flag is already set
  // on the final beat of every burst, so the consumer can frame items.
  jsu_burst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .push_req  (in_valid),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/json_string_unescape_utf8_test.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 100ps

module json_string_unescape_utf8_test
  import jsu_pkg::*;
();

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  // Random input beats to send after the directed tests.
  localparam int RANDOM_ITEMS = 410;
  // Cycles without any handshake on either side before the run is given up.
  localparam int STALL_LIMIT  = 4000;
  // Quiet cycles after the last expected beat, to catch stray extra beats.
  localparam int DRAIN_CYCLES = 8;
  // Mismatches beyond this count are still counted but no longer printed.
  localparam int PRINT_LIMIT  = 40;

  // Escape letters and the bytes they stand for.
  localparam logic [7:0] ESC_B = 8'h62;
  localparam logic [7:0] ESC_F = 8'h66;
  localparam logic [7:0] ESC_N = 8'h6E;
  localparam logic [7:0] ESC_R = 8'h72;
  localparam logic [7:0] ESC_T = 8'h74;
  localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
  localparam logic [7:0] BYTE_FORMFEED  = 8'h0C;
  localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
  localparam logic [7:0] BYTE_RETURN    = 8'h0D;
  localparam logic [7:0] BYTE_TAB       = 8'h09;

  // Bounds of the hex digit characters.
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  localparam logic [7:0] SIMPLE_LETTERS [8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH,
                                                ESC_B, ESC_F, ESC_N, ESC_R, ESC_T};

  // Where the decoder stands within the string body.
  typedef enum logic [2:0] {
    SCAN_PLAIN       = 3'd0,
    SCAN_ESCAPE      = 3'd1,
    SCAN_HEX         = 3'd2,
    SCAN_HIGH_HELD   = 3'd3,
    SCAN_HIGH_ESCAPE = 3'd4
  } scan_mode_t;

  // Styles of the receiver's stall pattern.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE
  } ready_style_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Decoder state as this bench predicts it.
  scan_mode_t  scan_mode  = SCAN_PLAIN;
  logic [15:0] hex_accum  = '0;
  logic [1:0]  hex_count  = '0;
  logic [15:0] held_high  = '0;
  logic        held_valid = 1'b0;

  // Beats caused by the item being decoded, and every beat still owed by the block.
  out_t item_beats[$];
  out_t decoded_beats[$];

  int mismatch_count = 0;
  int beats_sent     = 0;
  int burst_left     = 0;
  int quiet_cycles   = 0;

  always #HALF_PERIOD clk = ~clk;

  json_string_unescape_utf8 u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Decoding predictor
  // ---------------------------------------------------------------------------

  // Bit 8 tells whether the letter is a simple escape; bits 7:0 give its byte.
  function automatic logic [8:0] escape_byte(logic [7:0] letter);
    case (letter)
      CH_QUOTE:     return {1'b1, CH_QUOTE};
      CH_BACKSLASH: return {1'b1, CH_BACKSLASH};
      CH_SLASH:     return {1'b1, CH_SLASH};
      ESC_B:        return {1'b1, BYTE_BACKSPACE};
      ESC_F:        return {1'b1, BYTE_FORMFEED};
      ESC_N:        return {1'b1, BYTE_NEWLINE};
      ESC_R:        return {1'b1, BYTE_RETURN};
      ESC_T:        return {1'b1, BYTE_TAB};
      default:      return 9'd0;
    endcase
  endfunction

  // Bit 4 tells whether the character is a hex digit; bits 3:0 give its value.
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return {1'b1, 4'(c - CH_DIGIT0)};
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 4'd10) return CH_DIGIT0 + 8'(nib);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
  endfunction

  task automatic clear_scan();
    scan_mode  = SCAN_PLAIN;
    hex_accum  = '0;
    hex_count  = '0;
    held_high  = '0;
    held_valid = 1'b0;
  endtask

  task automatic emit_byte(logic [7:0] b);
    out_t r;
    r            = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    item_beats.push_back(r);
  endtask

  // UTF-8 encoding of one code point, one to four bytes.
  task automatic emit_code_point(logic [20:0] cp);
    if (cp < LIMIT_1BYTE) begin
      emit_byte(cp[7:0]);
    end else if (cp < LIMIT_2BYTE) begin
      emit_byte(UTF8_LEAD2 | 8'(cp >> 6));
      emit_byte(UTF8_CONT | {2'b00, cp[5:0]});
    end else if (cp < SUPP_BASE) begin
      emit_byte(UTF8_LEAD3 | 8'(cp >> 12));
      emit_byte(UTF8_CONT | {2'b00, cp[11:6]});
      emit_byte(UTF8_CONT | {2'b00, cp[5:0]});
    end else begin
      emit_byte(UTF8_LEAD4 | 8'(cp >> 18));
      emit_byte(UTF8_CONT | {2'b00, cp[17:12]});
      emit_byte(UTF8_CONT | {2'b00, cp[11:6]});
      emit_byte(UTF8_CONT | {2'b00, cp[5:0]});
    end
  endtask

  // An error wipes whatever the item had produced, a held surrogate included,
  // and leaves a single status beat behind.
  task automatic emit_error(logic [2:0] code);
    out_t r;
    clear_scan();
    item_beats.delete();
    r        = '0;
    r.status = code;
    item_beats.push_back(r);
  endtask

  // Works out the beats that one accepted input item causes and queues them.
  task automatic unescape_step(in_t it);
    logic [8:0]  esc;
    logic [4:0]  nib;
    logic [15:0] code;
    logic [15:0] hi;
    logic        to_plain;
    logic        paired;
    out_t        r;
    item_beats.delete();
    to_plain = 1'b0;
    case (scan_mode)
      SCAN_HIGH_HELD: begin
        // A high surrogate waits for a backslash; anything else flushes it.
        if (it.text_end) begin
          emit_error(STATUS_NO_QUOTE);
        end else if (it.in_byte == CH_BACKSLASH) begin
          scan_mode = SCAN_HIGH_ESCAPE;
        end else begin
          emit_code_point({5'd0, held_high});
          held_high  = '0;
          held_valid = 1'b0;
          scan_mode  = SCAN_PLAIN;
          to_plain   = 1'b1;
        end
      end
      SCAN_ESCAPE, SCAN_HIGH_ESCAPE: begin
        esc = escape_byte(it.in_byte);
        if (it.text_end) begin
          emit_error(STATUS_OPEN_ESCAPE);
        end else if (it.in_byte == CH_U) begin
          scan_mode = SCAN_HEX;
          hex_accum = '0;
          hex_count = '0;
        end else if (!esc[8]) begin
          emit_error(STATUS_BAD_ESCAPE);
        end else begin
          if (scan_mode == SCAN_HIGH_ESCAPE) emit_code_point({5'd0, held_high});
          held_high  = '0;
          held_valid = 1'b0;
          emit_byte(esc[7:0]);
          scan_mode = SCAN_PLAIN;
        end
      end
      SCAN_HEX: begin
        nib = hex_nibble(it.in_byte);
        if (it.text_end) begin
          emit_error(STATUS_SHORT_HEX);
        end else if (!nib[4]) begin
          emit_error(STATUS_BAD_HEX);
        end else begin
          hex_accum = {hex_accum[11:0], nib[3:0]};
          if (hex_count != 2'd3) begin
            hex_count = hex_count + 2'd1;
          end else begin
            // Fourth digit: the escape is complete.
            code      = hex_accum;
            hex_accum = '0;
            hex_count = '0;
            scan_mode = SCAN_PLAIN;
            paired    = 1'b0;
            if (held_valid) begin
              hi         = held_high;
              held_high  = '0;
              held_valid = 1'b0;
              if (code >= LOW_SURR_MIN && code <= LOW_SURR_MAX) begin
                emit_code_point(SUPP_BASE + (21'(hi - HIGH_SURR_MIN) << 10) +
                                21'(code - LOW_SURR_MIN));
                paired = 1'b1;
              end else begin
                emit_code_point({5'd0, hi});
              end
            end
            if (!paired) begin
              if (code >= HIGH_SURR_MIN && code <= HIGH_SURR_MAX) begin
                held_high  = code;
                held_valid = 1'b1;
                scan_mode  = SCAN_HIGH_HELD;
              end else begin
                emit_code_point({5'd0, code});
              end
            end
          end
        end
      end
      default: begin
        to_plain = 1'b1;
      end
    endcase

    if (to_plain) begin
      if (it.text_end) begin
        emit_error(STATUS_NO_QUOTE);
      end else if (it.in_byte == CH_QUOTE) begin
        clear_scan();
        r             = '0;
        r.string_done = 1'b1;
        item_beats.push_back(r);
      end else if (it.in_byte == CH_BACKSLASH) begin
        scan_mode = SCAN_ESCAPE;
      end else begin
        scan_mode = SCAN_PLAIN;
        emit_byte(it.in_byte);
      end
    end

    // The final beat of the item carries last.
    foreach (item_beats[i]) begin
      r      = item_beats[i];
      r.last = (i == item_beats.size() - 1);
      decoded_beats.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Sends one input beat. It is entered and left at a falling edge. The sender
  // works in bursts; at the start of a burst it may pause with valid low. Valid
  // is left high after acceptance so back-to-back beats never drop it.
  task automatic send_beat(logic [7:0] b, logic e);
    int   gap;
    in_t  it;
    it.in_byte  = b;
    it.text_end = e;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    unescape_step(it);
    beats_sent++;
    @(negedge clk);
  endtask

  // A complete \uXXXX escape; each set bit of upper writes that digit in
  // upper case, counting from the least significant digit.
  task automatic send_hex_escape(logic [15:0] code, logic [3:0] upper);
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      send_beat(hex_char(code[i*4 +: 4], upper[i]), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The receiver switches between stretches of full speed, coin-flip stalls
  // and mostly-stalled spells, each of random length.
  ready_style_t ready_style = READY_ALWAYS;
  int           ready_left  = 0;

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 2));
      ready_left  = $urandom_range(8, 80);
    end
    ready_left--;
    case (ready_style)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
      default:      out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  // Every accepted output beat is compared field by field with the oldest
  // expected beat.
  always @(posedge clk) begin : check_beats
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_beats.size() == 0) begin
        report_mismatch($sformatf("beat %h arrived with nothing expected", out_data));
      end else begin
        want = decoded_beats.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte: got %h, expected %h",
                                    out_data.out_byte, want.out_byte));
        if (out_data.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid: got %b, expected %b",
                                    out_data.byte_valid, want.byte_valid));
        if (out_data.string_done !== want.string_done)
          report_mismatch($sformatf("string_done: got %b, expected %b",
                                    out_data.string_done, want.string_done));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status: got %0d, expected %0d",
                                    out_data.status, want.status));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last: got %b, expected %b",
                                    out_data.last, want.last));
      end
    end
  end

  // Watchdog: a long stretch with no handshake on either side means the
  // block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // End of text before any byte of the body: unterminated string.
  task automatic test_end_at_start();
    send_beat(8'($urandom), 1'b1);
  endtask

  // Extreme raw bytes pass through; a known escape decodes; an unknown escape
  // letter gives an invalid escape status.
  task automatic test_plain_and_escapes();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat(ESC_N, 1'b0);
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat(8'h71, 1'b0);
  endtask

  // A high and a low surrogate combine into one 4-byte sequence, digits in
  // upper case first and lower case second; the closing quote ends the string.
  task automatic test_surrogate_pair();
    send_hex_escape(16'hD83D, 4'hF);
    send_hex_escape(16'hDE00, 4'h0);
    send_beat(CH_QUOTE, 1'b0);
  endtask

  // A held high surrogate followed by a 3-byte code point gives six beats for
  // one item; then the text ends inside a hex escape.
  task automatic test_lone_high_surrogate();
    send_hex_escape(16'hDBFF, 4'h5);
    send_hex_escape(16'hFFFF, 4'hA);
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat(CH_U, 1'b0);
    send_beat(CH_DIGIT0, 1'b0);
    send_beat(8'($urandom), 1'b1);
  endtask

  // Mostly well-formed string bodies with random content, mixed with broken
  // escapes, raw noise and every way a text can end early.
  task automatic test_random_strings();
    int          start;
    int          tokens;
    int          kind;
    int          ending;
    int          digits;
    logic        broken;
    logic [7:0]  b;
    logic [8:0]  esc;
    logic [4:0]  nib;
    logic [15:0] code;
    start = beats_sent;
    while (beats_sent - start < RANDOM_ITEMS) begin
      tokens = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
      broken = 1'b0;
      for (int t = 0; t < tokens && !broken; t++) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          // Raw byte; quote and backslash are nudged to a neighbor.
          b = 8'($urandom);
          if (b == CH_QUOTE || b == CH_BACKSLASH) b = b ^ 8'h01;
          send_beat(b, 1'b0);
        end else if (kind < 50) begin
          send_beat(CH_BACKSLASH, 1'b0);
          send_beat(SIMPLE_LETTERS[$urandom_range(0, 7)], 1'b0);
        end else if (kind < 64) begin
          case ($urandom_range(0, 2))
            0:       code = 16'($urandom_range(16'h0000, 16'h007F));
            1:       code = 16'($urandom_range(16'h0080, 16'h07FF));
            default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
          endcase
          send_hex_escape(code, 4'($urandom));
        end else if (kind < 74) begin
          send_hex_escape(16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX)), 4'($urandom));
          send_hex_escape(16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX)), 4'($urandom));
        end else if (kind < 82) begin
          // Lone high surrogate: whatever follows decides how it is flushed.
          send_hex_escape(16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX)), 4'($urandom));
        end else if (kind < 86) begin
          send_hex_escape(16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX)), 4'($urandom));
        end else if (kind < 90) begin
          // Unknown escape letter.
          do begin
            b   = 8'($urandom);
            esc = escape_byte(b);
          end while (esc[8] || b == CH_U);
          send_beat(CH_BACKSLASH, 1'b0);
          send_beat(b, 1'b0);
          broken = 1'b1;
        end else if (kind < 94) begin
          // A non-hex character somewhere among the four digits.
          do begin
            b   = 8'($urandom);
            nib = hex_nibble(b);
          end while (nib[4]);
          send_beat(CH_BACKSLASH, 1'b0);
          send_beat(CH_U, 1'b0);
          digits = $urandom_range(0, 3);
          repeat (digits) send_beat(hex_char(4'($urandom), 1'($urandom)), 1'b0);
          send_beat(b, 1'b0);
          broken = 1'b1;
        end else begin
          // Raw noise, end of text included now and then.
          send_beat(8'($urandom), ($urandom_range(0, 7) == 0));
        end
      end
      if (!broken) begin
        ending = $urandom_range(0, 99);
        if (ending < 78) begin
          send_beat(CH_QUOTE, 1'b0);
        end else if (ending < 88) begin
          send_beat(8'($urandom), 1'b1);
        end else if (ending < 94) begin
          send_beat(CH_BACKSLASH, 1'b0);
          send_beat(8'($urandom), 1'b1);
        end else begin
          send_beat(CH_BACKSLASH, 1'b0);
          send_beat(CH_U, 1'b0);
          digits = $urandom_range(0, 3);
          repeat (digits) send_beat(hex_char(4'($urandom), 1'($urandom)), 1'b0);
          send_beat(8'($urandom), 1'b1);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_end_at_start();
    test_plain_and_escapes();
    test_surrogate_pair();
    test_lone_high_surrogate();
    test_random_strings();

    // All input is in; let the block drain, then watch a little longer for
    // beats that should not be there. The watchdog bounds the wait.
    in_valid <= 1'b0;
    while (decoded_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
